>>> rtl/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing drive sequencer package
// Shared codes, datapath operations and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int CfgDataWidth = 12;
    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] CFG_POWER_FLOOR = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_POWER_CEILING = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_GAIN_PROP = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_GAIN_INTEG = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_TICK_LIMIT = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_DISTANCE_LIMIT = 3'd6;

    localparam logic [6:0] RST_POWER_FLOOR = 7'd38;
    localparam logic [6:0] RST_POWER_CEILING = 7'd64;
    localparam logic [7:0] RST_GAIN_PROP = 8'd77;
    localparam logic [7:0] RST_GAIN_INTEG = 8'd77;
    localparam logic [7:0] RST_INTEG_LIMIT = 8'd15;
    localparam logic [7:0] RST_TICK_LIMIT = 8'd20;
    localparam logic [11:0] RST_DISTANCE_LIMIT = 12'd500;
    localparam logic [11:0] RST_HEIGHT = 12'd10;
    localparam logic [7:0] RST_SETPOINT = 8'd100;

    localparam logic [7:0] SETPOINT_BASE = 8'd75;
    localparam logic [7:0] SETPOINT_SCALE = 8'd150;
    localparam logic [3:0] COUNT_MIN = 4'd10;
    localparam logic [4:0] IDLE_COUNT_MIN = 5'd20;
    localparam logic [1:0] SWING_TICK_MIN = 2'd2;

    localparam logic [2:0] PH_PULL_START = 3'd0;
    localparam logic [2:0] PH_PULL_END = 3'd1;
    localparam logic [2:0] PH_SWING_START = 3'd2;
    localparam logic [2:0] PH_SWING_END = 3'd3;
    localparam logic [2:0] PH_IDLE = 3'd4;

    localparam logic [1:0] CMD_STOP = 2'd0;
    localparam logic [1:0] CMD_RAMP = 2'd1;
    localparam logic [1:0] CMD_NONE = 2'd2;

    localparam logic RAMP_SLOW = 1'b0;
    localparam logic RAMP_FAST = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_EVAL,
        OP_HU_SQ,
        OP_HU_SET,
        OP_HU_ERR,
        OP_HU_MUL,
        OP_HU_PWR,
        OP_ENTER_RULE,
        OP_ABORT,
        OP_NEXT_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic rule_fire;
        logic rule_update;
        logic out_last;
    } status_t;

endpackage

>>> rtl/swing_drive_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing drive sequencer
// Encoder-event phase sequencer with PI drive power and motor commands.
//
//   channel  direction  ports                           handshake
//   s_       in         encoder_speed, knob_level       s_valid / s_ready
//   m_       out        command_kind .. drive_power,    m_valid / m_ready
//                       last (1 to 3 results per event)
//   cfg_     in         cfg_index, cfg_wr_data          cfg_wr_en
//
// From its transfer an event passes the evaluate and abort steps to its first
// result; a firing phase rule adds the enter step, and a height update also
// adds the five-step height/PI sequence in the datapath. Each further result
// follows as m_ready takes the one before. One event is in flight.
// Synchronous reset (aresetn) restores all but the operand and queue registers.
// A stalled m_ready holds the current result; s_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module swing_drive_sequencer_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sds_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [sds_pkg::CfgDataWidth-1:0]     cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [7:0]                    s_encoder_speed,
    input  logic [9:0]                           s_knob_level,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_command_kind,
    output logic [6:0]                           m_target_power,
    output logic                                 m_ramp_code,
    output logic [2:0]                           m_phase,
    output logic [11:0]                          m_height_estimate,
    output logic [7:0]                           m_height_target,
    output logic [6:0]                           m_drive_power,
    output logic                                 m_last
);

    sds_pkg::ctrl_t   ctrl;
    sds_pkg::status_t status;

    sds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .ctrl    (ctrl),
        .status  (status)
    );

    sds_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .ctrl              (ctrl),
        .status            (status),
        .s_encoder_speed   (s_encoder_speed),
        .s_knob_level      (s_knob_level),
        .m_command_kind    (m_command_kind),
        .m_target_power    (m_target_power),
        .m_ramp_code       (m_ramp_code),
        .m_phase           (m_phase),
        .m_height_estimate (m_height_estimate),
        .m_height_target   (m_height_target),
        .m_drive_power     (m_drive_power)
    );

endmodule

>>> rtl/sds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing drive sequencer datapath
// Configuration, counters, phase rule, height/PI update and command queue.
// ----------------------------------------------------------------------------
module sds_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sds_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [sds_pkg::CfgDataWidth-1:0]     cfg_wr_data,
    input  sds_pkg::ctrl_t                       ctrl,
    output sds_pkg::status_t                     status,
    input  logic [7:0]                           s_encoder_speed,
    input  logic [9:0]                           s_knob_level,
    output logic [1:0]                           m_command_kind,
    output logic [6:0]                           m_target_power,
    output logic                                 m_ramp_code,
    output logic [2:0]                           m_phase,
    output logic [11:0]                          m_height_estimate,
    output logic [7:0]                           m_height_target,
    output logic [6:0]                           m_drive_power
);

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] target;
        logic       ramp;
    } cmd_entry_t;

    localparam logic [7:0] SETPOINT_SCALE_W = sds_pkg::SETPOINT_SCALE;

    logic [6:0]  floor_reg, ceil_reg;
    logic [7:0]  gain_prop_reg, gain_integ_reg, integ_limit_reg, tick_limit_reg;
    logic [11:0] distance_limit_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [11:0] dist_reg, dist_next;
    logic [7:0]  tick_reg, tick_next;
    logic [11:0] height_reg, height_next;
    logic [7:0]  setpoint_reg, setpoint_next;
    logic signed [8:0] integ_reg, integ_next;
    logic [6:0]  power_reg, power_next;

    logic [7:0]  speed_reg, speed_next;
    logic [9:0]  knob_reg, knob_next;
    logic [2:0]  rule_phase_reg, rule_phase_next;
    logic [19:0] sq_reg, sq_next;
    logic signed [12:0] e_reg, e_next;
    logic signed [13:0] acc_reg, acc_next;
    logic signed [21:0] pe_reg, pe_next;
    logic signed [22:0] pa_reg, pa_next;

    cmd_entry_t  q_reg [3];
    cmd_entry_t  q_next [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg, idx_next;

    logic [7:0]  mag;
    logic [12:0] dist_sum;
    logic [12:0] height_sum;
    logic [27:0] sp_prod;
    logic [14:0] n5, h4;
    logic [14:0] power_base;
    logic signed [24:0] pi_sum;
    logic [15:0] pi_q, pw_wide;
    logic signed [13:0] lim_s, integ_wide;
    logic        rule_fire, rule_update;
    logic [2:0]  rule_ph;
    logic        enter_en;
    logic [2:0]  enter_ph;
    logic [1:0]  push_n;
    cmd_entry_t  push0, push1;

    assign mag = speed_next[7] ? (~speed_next + 8'd1) : speed_next;
    assign dist_sum = {1'b0, dist_reg} + {5'b0, mag};
    assign height_sum = {1'b0, height_reg} + {1'b0, dist_reg};
    assign sp_prod = sq_reg * SETPOINT_SCALE_W;
    assign n5 = {dist_reg, 2'b00} + {3'b0, dist_reg};
    assign h4 = {1'b0, height_reg, 2'b00};
    assign power_base = {({1'b0, floor_reg} + {1'b0, ceil_reg}), 7'b0};
    assign pi_sum = $signed({10'b0, power_base}) + $signed({{3{pe_reg[21]}}, pe_reg})
                  + $signed({{2{pa_reg[22]}}, pa_reg});
    assign pi_q = pi_sum[23:8];
    assign lim_s = $signed({6'b0, integ_limit_reg});

    always_comb begin
        rule_fire = 1'b0;
        rule_update = 1'b0;
        rule_ph = phase_reg;
        case (phase_reg)
            sds_pkg::PH_PULL_START: begin
                rule_fire = n5 > h4;
                rule_ph = sds_pkg::PH_PULL_END;
            end
            sds_pkg::PH_PULL_END: begin
                rule_fire = (dist_reg > {8'b0, sds_pkg::COUNT_MIN})
                          && (speed_reg[7] || speed_reg == 8'd0);
                rule_update = 1'b1;
                rule_ph = sds_pkg::PH_SWING_START;
            end
            sds_pkg::PH_SWING_START: begin
                rule_fire = {dist_reg, 1'b0} > {1'b0, height_reg};
                rule_ph = sds_pkg::PH_SWING_END;
            end
            sds_pkg::PH_SWING_END: begin
                rule_fire = (tick_reg > {6'b0, sds_pkg::SWING_TICK_MIN})
                          && (dist_reg > {8'b0, sds_pkg::COUNT_MIN}) && !speed_reg[7];
                rule_update = 1'b1;
                rule_ph = sds_pkg::PH_PULL_START;
            end
            sds_pkg::PH_IDLE: begin
                rule_fire = (tick_reg > {3'b0, sds_pkg::IDLE_COUNT_MIN})
                          && (dist_reg >= {7'b0, sds_pkg::IDLE_COUNT_MIN});
                rule_ph = sds_pkg::PH_SWING_END;
            end
            default: begin
                rule_fire = 1'b0;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        dist_next = dist_reg;
        tick_next = tick_reg;
        height_next = height_reg;
        setpoint_next = setpoint_reg;
        integ_next = integ_reg;
        power_next = power_reg;
        speed_next = speed_reg;
        knob_next = knob_reg;
        rule_phase_next = rule_phase_reg;
        sq_next = sq_reg;
        e_next = e_reg;
        acc_next = acc_reg;
        pe_next = pe_reg;
        pa_next = pa_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        enter_en = 1'b0;
        enter_ph = phase_reg;
        push_n = 2'd0;
        push0 = '0;
        push1 = '0;
        pw_wide = '0;
        integ_wide = acc_reg;
        case (ctrl.op)
            sds_pkg::OP_LOAD: begin
                speed_next = s_encoder_speed;
                knob_next = s_knob_level;
                tick_next = (tick_reg == 8'hFF) ? tick_reg : tick_reg + 8'd1;
                dist_next = dist_sum[12] ? 12'hFFF : dist_sum[11:0];
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end
            sds_pkg::OP_EVAL: begin
                rule_phase_next = rule_ph;
            end
            sds_pkg::OP_HU_SQ: begin
                height_next = height_sum[12:1];
                sq_next = knob_reg * knob_reg;
            end
            sds_pkg::OP_HU_SET: begin
                setpoint_next = sds_pkg::SETPOINT_BASE + sp_prod[27:20];
            end
            sds_pkg::OP_HU_ERR: begin
                e_next = $signed({5'b0, setpoint_reg}) - $signed({1'b0, height_reg});
                acc_next = $signed({{5{integ_reg[8]}}, integ_reg})
                         + $signed({e_next[12], e_next});
            end
            sds_pkg::OP_HU_MUL: begin
                pe_next = e_reg * $signed({1'b0, gain_prop_reg});
                pa_next = acc_reg * $signed({1'b0, gain_integ_reg});
            end
            sds_pkg::OP_HU_PWR: begin
                if (pi_sum[24] || pi_q < {9'b0, floor_reg}) begin
                    pw_wide = {9'b0, floor_reg};
                end else begin
                    pw_wide = pi_q;
                end
                power_next = (pw_wide > {9'b0, ceil_reg}) ? ceil_reg : pw_wide[6:0];
                if (acc_reg < -lim_s) begin
                    integ_wide = -lim_s;
                end else if (acc_reg > lim_s) begin
                    integ_wide = lim_s;
                end else begin
                    integ_wide = acc_reg;
                end
                integ_next = integ_wide[8:0];
            end
            sds_pkg::OP_ENTER_RULE: begin
                enter_en = 1'b1;
                enter_ph = rule_phase_reg;
            end
            sds_pkg::OP_ABORT: begin
                enter_en = (tick_reg > tick_limit_reg) || (dist_reg > distance_limit_reg);
                enter_ph = sds_pkg::PH_IDLE;
            end
            sds_pkg::OP_NEXT_OUT: begin
                idx_next = idx_reg + 2'd1;
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase

        if (enter_en && enter_ph != phase_reg) begin
            phase_next = enter_ph;
            tick_next = 8'd0;
            if (enter_ph == sds_pkg::PH_PULL_START || enter_ph == sds_pkg::PH_SWING_START
                || enter_ph == sds_pkg::PH_IDLE) begin
                dist_next = 12'd0;
            end
            case (enter_ph)
                sds_pkg::PH_PULL_END: begin
                    push_n = 2'd1;
                    push0 = '{kind: sds_pkg::CMD_RAMP, target: floor_reg,
                              ramp: sds_pkg::RAMP_SLOW};
                end
                sds_pkg::PH_SWING_START, sds_pkg::PH_IDLE: begin
                    push_n = 2'd1;
                    push0 = '{kind: sds_pkg::CMD_STOP, target: 7'd0,
                              ramp: sds_pkg::RAMP_SLOW};
                end
                sds_pkg::PH_SWING_END: begin
                    push_n = 2'd2;
                    push0 = '{kind: sds_pkg::CMD_STOP, target: 7'd0,
                              ramp: sds_pkg::RAMP_SLOW};
                    push1 = '{kind: sds_pkg::CMD_RAMP, target: power_reg,
                              ramp: sds_pkg::RAMP_FAST};
                end
                default: begin
                    push_n = 2'd0;
                end
            endcase
        end

        if (push_n != 2'd0 && cnt_reg < 2'd3) begin
            q_next[cnt_reg] = push0;
            cnt_next = cnt_reg + 2'd1;
        end
        if (push_n == 2'd2 && cnt_reg < 2'd2) begin
            q_next[cnt_reg + 2'd1] = push1;
            cnt_next = cnt_reg + 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= sds_pkg::RST_POWER_FLOOR;
            ceil_reg <= sds_pkg::RST_POWER_CEILING;
            gain_prop_reg <= sds_pkg::RST_GAIN_PROP;
            gain_integ_reg <= sds_pkg::RST_GAIN_INTEG;
            integ_limit_reg <= sds_pkg::RST_INTEG_LIMIT;
            tick_limit_reg <= sds_pkg::RST_TICK_LIMIT;
            distance_limit_reg <= sds_pkg::RST_DISTANCE_LIMIT;
            phase_reg <= sds_pkg::PH_SWING_END;
            dist_reg <= 12'd0;
            tick_reg <= 8'd0;
            height_reg <= sds_pkg::RST_HEIGHT;
            setpoint_reg <= sds_pkg::RST_SETPOINT;
            integ_reg <= 9'sd0;
            power_reg <= sds_pkg::RST_POWER_CEILING;
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    sds_pkg::CFG_POWER_FLOOR: floor_reg <= cfg_wr_data[6:0];
                    sds_pkg::CFG_POWER_CEILING: ceil_reg <= cfg_wr_data[6:0];
                    sds_pkg::CFG_GAIN_PROP: gain_prop_reg <= cfg_wr_data[7:0];
                    sds_pkg::CFG_GAIN_INTEG: gain_integ_reg <= cfg_wr_data[7:0];
                    sds_pkg::CFG_INTEG_LIMIT: integ_limit_reg <= cfg_wr_data[7:0];
                    sds_pkg::CFG_TICK_LIMIT: tick_limit_reg <= cfg_wr_data[7:0];
                    sds_pkg::CFG_DISTANCE_LIMIT: distance_limit_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            phase_reg <= phase_next;
            dist_reg <= dist_next;
            tick_reg <= tick_next;
            height_reg <= height_next;
            setpoint_reg <= setpoint_next;
            integ_reg <= integ_next;
            power_reg <= power_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        speed_reg <= speed_next;
        knob_reg <= knob_next;
        rule_phase_reg <= rule_phase_next;
        sq_reg <= sq_next;
        e_reg <= e_next;
        acc_reg <= acc_next;
        pe_reg <= pe_next;
        pa_reg <= pa_next;
        q_reg <= q_next;
    end

    assign status.rule_fire = rule_fire;
    assign status.rule_update = rule_update;
    assign status.out_last = (cnt_reg == 2'd0) || (idx_reg == cnt_reg - 2'd1);

    assign m_command_kind = (cnt_reg == 2'd0) ? sds_pkg::CMD_NONE : q_reg[idx_reg].kind;
    assign m_target_power = (cnt_reg == 2'd0) ? 7'd0 : q_reg[idx_reg].target;
    assign m_ramp_code = (cnt_reg == 2'd0) ? sds_pkg::RAMP_SLOW : q_reg[idx_reg].ramp;
    assign m_phase = phase_reg;
    assign m_height_estimate = height_reg;
    assign m_height_target = setpoint_reg;
    assign m_drive_power = power_reg;

    a_integ_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == sds_pkg::OP_HU_PWR && !cfg_wr_en)
        |=> ($signed({{5{integ_reg[8]}}, integ_reg}) <= lim_s
             && $signed({{5{integ_reg[8]}}, integ_reg}) >= -lim_s))
        else $error("integrator outside its clamp after update");

    a_power_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == sds_pkg::OP_HU_PWR && !cfg_wr_en) |=> power_reg <= ceil_reg)
        else $error("drive power above ceiling after update");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == sds_pkg::OP_NEXT_OUT |-> idx_reg + 2'd1 < cnt_reg)
        else $error("advance past last queued command");

endmodule

>>> rtl/sds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing drive sequencer controller
// Sequences one encoder event through the datapath and hands out its results.
// ----------------------------------------------------------------------------
module sds_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_last,
    output sds_pkg::ctrl_t     ctrl,
    input  sds_pkg::status_t   status
);

    typedef enum logic [3:0] {
        S_WAIT,
        S_EVAL,
        S_SQ,
        S_SET,
        S_ERR,
        S_MUL,
        S_PWR,
        S_ENTER,
        S_ABORT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg;
        ctrl.op = sds_pkg::OP_NOP;
        case (state_reg)
            S_WAIT: begin
                if (s_valid) begin
                    ctrl.op = sds_pkg::OP_LOAD;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                ctrl.op = sds_pkg::OP_EVAL;
                if (!status.rule_fire) begin
                    state_next = S_ABORT;
                end else if (status.rule_update) begin
                    state_next = S_SQ;
                end else begin
                    state_next = S_ENTER;
                end
            end
            S_SQ: begin
                ctrl.op = sds_pkg::OP_HU_SQ;
                state_next = S_SET;
            end
            S_SET: begin
                ctrl.op = sds_pkg::OP_HU_SET;
                state_next = S_ERR;
            end
            S_ERR: begin
                ctrl.op = sds_pkg::OP_HU_ERR;
                state_next = S_MUL;
            end
            S_MUL: begin
                ctrl.op = sds_pkg::OP_HU_MUL;
                state_next = S_PWR;
            end
            S_PWR: begin
                ctrl.op = sds_pkg::OP_HU_PWR;
                state_next = S_ENTER;
            end
            S_ENTER: begin
                ctrl.op = sds_pkg::OP_ENTER_RULE;
                state_next = S_ABORT;
            end
            S_ABORT: begin
                ctrl.op = sds_pkg::OP_ABORT;
                state_next = S_EMIT;
                m_valid_next = 1'b1;
            end
            S_EMIT: begin
                if (m_ready) begin
                    if (status.out_last) begin
                        state_next = S_WAIT;
                        m_valid_next = 1'b0;
                    end else begin
                        ctrl.op = sds_pkg::OP_NEXT_OUT;
                    end
                end
            end
            default: begin
                state_next = S_WAIT;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_WAIT);
    assign m_valid = m_valid_reg;
    assign m_last = status.out_last;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while results pending");

    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.out_last) |=> (s_ready && !m_valid))
        else $error("block not idle after final result");

    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == S_EMIT)
        else $error("result valid outside emit");

endmodule
